@@ rtl/handheld_io_interrupt_registers_assert.svh @@
// Assertion macros used by the I/O register page RTL.
`ifndef HANDHELD_IO_INTERRUPT_REGISTERS_ASSERT_SVH
`define HANDHELD_IO_INTERRUPT_REGISTERS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HHIO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HHIO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hhio_pkg.sv @@
package hhio_pkg;

    localparam int IRQ_LINES = 5;

    localparam logic [7:0] R_P1   = 8'h00;
    localparam logic [7:0] R_DIV  = 8'h04;
    localparam logic [7:0] R_IF   = 8'h0F;
    localparam logic [7:0] R_LCDC = 8'h40;
    localparam logic [7:0] R_STAT = 8'h41;
    localparam logic [7:0] R_LY   = 8'h44;
    localparam logic [7:0] R_DMA  = 8'h46;
    localparam logic [7:0] R_BGP  = 8'h47;
    localparam logic [7:0] R_OBP0 = 8'h48;
    localparam logic [7:0] R_OBP1 = 8'h49;
    localparam logic [7:0] R_IE   = 8'hFF;

    localparam logic [2:0] JOYPAD_LINE = 3'd4;
    localparam logic [7:0] VEC_BASE    = 8'h40;
    localparam logic [7:0] STAT_WMASK  = 8'hF8;
    localparam logic [7:0] STAT_KEEP   = 8'h07;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_RAISE   = 3'd2,
        OP_ACK     = 3'd3,
        OP_JOYPAD  = 3'd4,
        OP_ENABLE  = 3'd5,
        OP_DISABLE = 3'd6
    } op_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } page_wr_t;

    // Registers of the published map, including those held outside the page RAM.
    function automatic logic is_plain_reg(input logic [7:0] r);
        logic hit;
        hit = (r <= 8'h02)
            || (r >= 8'h04 && r <= 8'h07)
            || (r == R_IF)
            || (r >= 8'h10 && r <= 8'h14)
            || (r >= 8'h16 && r <= 8'h1E)
            || (r >= 8'h20 && r <= 8'h26)
            || (r >= 8'h30 && r <= 8'h3F)
            || (r >= 8'h40 && r <= 8'h45)
            || (r >= 8'h47 && r <= 8'h4B)
            || (r == R_IE);
        return hit;
    endfunction

    // P1: select bits from sel, low nibble is the AND of the selected key rows.
    function automatic logic [7:0] merge_p1(input logic [7:0] sel, input logic [7:0] joy);
        logic [3:0] lo;
        logic [3:0] hi;
        lo = sel[4] ? 4'hF : joy[3:0];
        hi = sel[5] ? 4'hF : joy[7:4];
        return {sel[7:4], lo & hi};
    endfunction

    // Power-on value of a page entry never written.
    function automatic logic [7:0] page_default(input logic [7:0] r);
        logic [7:0] v;
        unique case (r)
            R_P1:   v = 8'h0F;
            R_LCDC: v = 8'h91;
            R_BGP:  v = 8'hFC;
            R_OBP0: v = 8'hFF;
            R_OBP1: v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/hhio_ram.sv @@
module hhio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/hhio_page.sv @@
module hhio_page
    import hhio_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rd_en,
    input  logic [7:0] rd_addr,
    input  page_wr_t   wr,
    output logic [7:0] rd_data
);

    logic [255:0] valid_reg;
    logic         hit_reg;
    logic [7:0]   addr_reg;
    logic [7:0]   ram_q;

    hhio_ram #(
        .WIDTH(8),
        .DEPTH(256)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // Entry valid bits; unwritten entries read as their power-on value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            hit_reg  <= valid_reg[rd_addr];
            addr_reg <= rd_addr;
        end
    end

    assign rd_data = hit_reg ? ram_q : page_default(addr_reg);

endmodule

@@ rtl/handheld_io_interrupt_registers.sv @@
// I/O register page and interrupt controller of a handheld console. Each input
// transfer is one bus access (read or write, decoded on the low address byte)
// or one event (raise interrupt, acknowledge, joypad update, master enable on
// or off) and yields exactly one result transfer. The accept cycle issues the
// read of the 256-entry page RAM; in S_EXEC, entered in the next cycle, the
// item does the modify and write-back and loads the result register, as the
// page RAM read is registered. If a result is still held by out_ready low, the
// item waits in S_EXEC. A new item is taken while an earlier result still
// waits at the output. No clearing pass is needed after reset: every page
// entry has a valid bit, and an entry never written reads as its power-on
// value (LCDC 0x91, BGP 0xFC, OBP0/OBP1 0xFF).
// IF, IE, P1, STAT and LY live in flops next to the RAM, since events and
// video restarts touch them together with other registers.
`include "handheld_io_interrupt_registers_assert.svh"

module handheld_io_interrupt_registers
    import hhio_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic [2:0]  irq_number,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        undefined_access,
    output logic        ack_valid,
    output logic [7:0]  vector_address,
    output logic        video_restart,
    output logic        dma_start,
    output logic [7:0]  dma_page
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t     state_reg;
    state_t     state_next;

    // captured item
    op_t        op_reg;
    logic [7:0] addr_reg;
    logic [7:0] data_reg;
    logic [2:0] irq_reg;

    // registers held outside the page RAM
    logic [7:0] if_reg,   if_next;
    logic [7:0] ie_reg,   ie_next;
    logic [7:0] p1_reg,   p1_next;
    logic [7:0] stat_reg, stat_next;
    logic [7:0] ly_reg,   ly_next;
    logic       ime_reg,  ime_next;
    logic [7:0] joy_reg,  joy_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] rdata_reg,     rdata_next;
    logic       undef_reg,     undef_next;
    logic       ackv_reg,      ackv_next;
    logic [7:0] vec_reg,       vec_next;
    logic       vrst_reg,      vrst_next;
    logic       dmas_reg,      dmas_next;
    logic [7:0] dmap_reg,      dmap_next;

    logic       accept;
    logic       exec_done;
    logic [7:0] page_rdata;
    logic [7:0] read_mux;
    page_wr_t   page_wr;
    logic [7:0] pend;
    logic       found;
    logic [2:0] line;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign exec_done = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    hhio_page u_page (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (address[7:0]),
        .wr      (page_wr),
        .rd_data (page_rdata)
    );

    // Readback of a defined register other than IF.
    always_comb
    begin
        unique case (addr_reg)
            R_P1:    read_mux = p1_reg;
            R_STAT:  read_mux = stat_reg;
            R_LY:    read_mux = ly_reg;
            R_IE:    read_mux = ie_reg;
            default: read_mux = page_rdata;
        endcase
    end

    // Lowest pending enabled line.
    always_comb
    begin
        pend  = ime_reg ? (if_reg & ie_reg) : 8'h00;
        found = 1'b0;
        line  = '0;
        for (int k = IRQ_LINES - 1; k >= 0; k--)
        begin
            if (pend[k])
            begin
                found = 1'b1;
                line  = 3'(k);
            end
        end
    end

    // Modify and write back for the item in S_EXEC.
    always_comb
    begin
        if_next    = if_reg;
        ie_next    = ie_reg;
        p1_next    = p1_reg;
        stat_next  = stat_reg;
        ly_next    = ly_reg;
        ime_next   = ime_reg;
        joy_next   = joy_reg;
        rdata_next = '0;
        undef_next = 1'b0;
        ackv_next  = 1'b0;
        vec_next   = '0;
        vrst_next  = 1'b0;
        dmas_next  = 1'b0;
        dmap_next  = '0;
        page_wr    = '0;

        unique case (op_reg)
            OP_READ:
            begin
                if (addr_reg == R_IF)
                begin
                    rdata_next = ime_reg ? if_reg : 8'h00;
                end
                else if (is_plain_reg(addr_reg))
                begin
                    rdata_next = read_mux;
                end
                else
                begin
                    undef_next = 1'b1;
                end
            end
            OP_WRITE:
            begin
                priority if (addr_reg == R_DMA)
                begin
                    dmas_next = 1'b1;
                    dmap_next = data_reg;
                end
                else if (addr_reg == R_STAT)
                begin
                    stat_next  = (stat_reg & STAT_KEEP) | (data_reg & STAT_WMASK);
                    rdata_next = stat_next;
                end
                else if (addr_reg == R_LCDC)
                begin
                    if (!data_reg[7])
                    begin
                        ly_next   = '0;
                        stat_next = stat_reg & STAT_WMASK;
                        vrst_next = 1'b1;
                    end
                    page_wr    = '{en: 1'b1, addr: addr_reg, data: data_reg};
                    rdata_next = data_reg;
                end
                else if (addr_reg == R_P1)
                begin
                    p1_next    = merge_p1(data_reg, joy_reg);
                    rdata_next = p1_next;
                end
                else if (addr_reg == R_LY)
                begin
                    ly_next   = '0;
                    stat_next = stat_reg & STAT_WMASK;
                    vrst_next = 1'b1;
                end
                else if (addr_reg == R_DIV)
                begin
                    page_wr = '{en: 1'b1, addr: addr_reg, data: 8'h00};
                end
                else if (addr_reg == R_IF)
                begin
                    if_next    = data_reg;
                    rdata_next = data_reg;
                end
                else if (addr_reg == R_IE)
                begin
                    ie_next    = data_reg;
                    rdata_next = data_reg;
                end
                else if (is_plain_reg(addr_reg))
                begin
                    page_wr    = '{en: 1'b1, addr: addr_reg, data: data_reg};
                    rdata_next = data_reg;
                end
                else
                begin
                    undef_next = 1'b1;
                end
            end
            OP_RAISE:
            begin
                if ({1'b0, irq_reg} < 4'(IRQ_LINES))
                begin
                    if_next = if_reg | (8'h01 << irq_reg);
                end
            end
            OP_ACK:
            begin
                if (found)
                begin
                    if_next   = if_reg & ~(8'h01 << line);
                    ackv_next = 1'b1;
                    vec_next  = VEC_BASE | {2'b00, line, 3'b000};
                end
            end
            OP_JOYPAD:
            begin
                // any line going from high to low
                if ((joy_reg & data_reg) != joy_reg)
                begin
                    if_next = if_reg | (8'h01 << JOYPAD_LINE);
                end
                joy_next = data_reg;
                p1_next  = merge_p1(p1_reg, data_reg);
            end
            OP_ENABLE:  ime_next = 1'b1;
            OP_DISABLE: ime_next = 1'b0;
            default:
            begin
            end
        endcase

        page_wr.en = page_wr.en && exec_done;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (out_valid_reg && out_ready)
                begin
                    out_valid_next = 1'b0;
                end
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_done)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rdata_reg     <= '0;
            undef_reg     <= 1'b0;
            ackv_reg      <= 1'b0;
            vec_reg       <= '0;
            vrst_reg      <= 1'b0;
            dmas_reg      <= 1'b0;
            dmap_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec_done)
            begin
                rdata_reg <= rdata_next;
                undef_reg <= undef_next;
                ackv_reg  <= ackv_next;
                vec_reg   <= vec_next;
                vrst_reg  <= vrst_next;
                dmas_reg  <= dmas_next;
                dmap_reg  <= dmap_next;
            end
        end
    end

    // Captured item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(operation);
            addr_reg <= address[7:0];
            data_reg <= data;
            irq_reg  <= irq_number;
        end
    end

    // Flop-held registers, updated once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            if_reg   <= 8'h00;
            ie_reg   <= 8'h00;
            p1_reg   <= 8'h0F;
            stat_reg <= 8'h00;
            ly_reg   <= 8'h00;
            ime_reg  <= 1'b1;
            joy_reg  <= 8'hFF;
        end
        else if (exec_done)
        begin
            if_reg   <= if_next;
            ie_reg   <= ie_next;
            p1_reg   <= p1_next;
            stat_reg <= stat_next;
            ly_reg   <= ly_next;
            ime_reg  <= ime_next;
            joy_reg  <= joy_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign read_data        = rdata_reg;
    assign undefined_access = undef_reg;
    assign ack_valid        = ackv_reg;
    assign vector_address   = vec_reg;
    assign video_restart    = vrst_reg;
    assign dma_start        = dmas_reg;
    assign dma_page         = dmap_reg;

    // page RAM is never read and written in the same cycle
    `HHIO_ASSERT_NOW(a_no_rw_overlap, page_wr.en, !accept, "page write overlaps page read")
    // an accepted item is worked on in the next cycle
    `HHIO_ASSERT_NEXT(a_accept_exec, accept, state_reg == S_EXEC, "accepted item not in exec")
    // a vector is only reported with a valid acknowledge
    `HHIO_ASSERT_NOW(a_vec_ack, out_valid && !ack_valid, vector_address == 8'h00, "stray vector")
    // a video restart only comes from a defined write
    `HHIO_ASSERT_NOW(a_vrst_def, out_valid && video_restart, !undefined_access && !dma_start, "bad restart")

endmodule

@@ verif/tb_handheld_io_interrupt_registers.sv @@
// Testbench for the handheld I/O register page and interrupt controller.
module tb_handheld_io_interrupt_registers;
    import hhio_pkg::*;

    // Opcode 3'd7 is not in op_t; the block must treat it as a no-op.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // Slowest legal run: ~1550 transfers, each with the longest sender gap, the
    // longest receiver stall and its pass through the block. The limit is several
    // times that.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1525;
    localparam int TAIL_CYCLES  = 8;

    // One result transfer, field by field.
    typedef struct packed {
        logic [7:0] read_data;
        logic       undefined_access;
        logic       ack_valid;
        logic [7:0] vector_address;
        logic       video_restart;
        logic       dma_start;
        logic [7:0] dma_page;
    } io_result_t;

    localparam io_result_t ALL_ZERO = '0;

    // One stimulus row. When typed is set, want is the known answer and is
    // used in place of the predictor's.
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [2:0]  line;
        logic        typed;
        io_result_t  want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
    logic [2:0]  irq_number;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;
    logic        undefined_access;
    logic        ack_valid;
    logic [7:0]  vector_address;
    logic        video_restart;
    logic        dma_start;
    logic [7:0]  dma_page;

    // Shadow of the block's state, advanced once per accepted input transfer.
    logic [7:0]  page_mirror [256];
    logic        irq_master_on;
    logic [7:0]  key_levels;

    io_result_t  pending_results [$];
    stim_row_t   directed_rows [$];
    int          failures;
    int          cycle_count;
    bit          no_idle;

    handheld_io_interrupt_registers i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .address          (address),
        .data             (data),
        .irq_number       (irq_number),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .read_data        (read_data),
        .undefined_access (undefined_access),
        .ack_valid        (ack_valid),
        .vector_address   (vector_address),
        .video_restart    (video_restart),
        .dma_start        (dma_start),
        .dma_page         (dma_page)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Hard stop if the handshakes ever hang.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_handheld_io_interrupt_registers: FAIL");
            $finish;
        end
    end

    // Addresses of the published map (DMA is write-only, so it is left out).
    function automatic logic reg_mapped(input logic [7:0] r);
        logic hit;
        hit = 1'b0;
        if (r < 8'h03 || r == R_IF || r == R_IE)
            hit = 1'b1;
        else if (r > 8'h03 && r < 8'h08)
            hit = 1'b1;
        else if ((r > 8'h0F && r < 8'h15) || (r > 8'h15 && r < 8'h1F))
            hit = 1'b1;
        else if ((r > 8'h1F && r < 8'h27) || (r > 8'h2F && r < 8'h46))
            hit = 1'b1;
        else if (r > 8'h46 && r < 8'h4C)
            hit = 1'b1;
        return hit;
    endfunction

    // P1: bits 7:4 from the select value, each low bit is the AND of the key
    // rows whose select bit is low.
    function automatic logic [7:0] p1_from_keys(input logic [7:0] sel, input logic [7:0] keys);
        logic [3:0] row_a;
        logic [3:0] row_b;
        row_a = keys[3:0] | {4{sel[4]}};
        row_b = keys[7:4] | {4{sel[5]}};
        return {sel[7:4], row_a & row_b};
    endfunction

    // Predicts the result of one bus access or event and updates the shadow.
    function automatic io_result_t step_io_page(input logic [2:0] op, input logic [15:0] addr,
                                               input logic [7:0] wdata, input logic [2:0] line);
        io_result_t res;
        logic [7:0] r;
        logic [7:0] pend;
        logic       found;
        res = ALL_ZERO;
        r = addr[7:0];
        case (op)
            OP_READ:
            begin
                if (r == R_IF)
                    res.read_data = irq_master_on ? page_mirror[R_IF] : 8'h00;
                else if (reg_mapped(r))
                    res.read_data = page_mirror[r];
                else
                    res.undefined_access = 1'b1;
            end
            OP_WRITE:
            begin
                if (r == R_DMA)
                begin
                    res.dma_start = 1'b1;
                    res.dma_page  = wdata;
                end
                else if (r == R_STAT)
                begin
                    page_mirror[R_STAT] = (page_mirror[R_STAT] & STAT_KEEP) | (wdata & STAT_WMASK);
                    res.read_data = page_mirror[R_STAT];
                end
                else if (r == R_LCDC)
                begin
                    // display off restarts video timing
                    if (!wdata[7])
                    begin
                        page_mirror[R_LY]   = 8'h00;
                        page_mirror[R_STAT] = page_mirror[R_STAT] & STAT_WMASK;
                        res.video_restart   = 1'b1;
                    end
                    page_mirror[R_LCDC] = wdata;
                    res.read_data = wdata;
                end
                else if (r == R_P1)
                begin
                    page_mirror[R_P1] = p1_from_keys(wdata, key_levels);
                    res.read_data = page_mirror[R_P1];
                end
                else if (r == R_LY)
                begin
                    page_mirror[R_LY]   = 8'h00;
                    page_mirror[R_STAT] = page_mirror[R_STAT] & STAT_WMASK;
                    res.video_restart   = 1'b1;
                end
                else if (r == R_DIV)
                    page_mirror[R_DIV] = 8'h00;
                else if (reg_mapped(r))
                begin
                    page_mirror[r] = wdata;
                    res.read_data = wdata;
                end
                else
                    res.undefined_access = 1'b1;
            end
            OP_RAISE:
            begin
                if (line < IRQ_LINES)
                    page_mirror[R_IF][line] = 1'b1;
            end
            OP_ACK:
            begin
                pend = irq_master_on ? (page_mirror[R_IF] & page_mirror[R_IE]) : 8'h00;
                found = 1'b0;
                for (int i = 0; i < IRQ_LINES; i++)
                begin
                    if (!found && pend[i])
                    begin
                        found = 1'b1;
                        page_mirror[R_IF][i] = 1'b0;
                        res.ack_valid = 1'b1;
                        res.vector_address = VEC_BASE + 8'(8 * i);
                    end
                end
            end
            OP_JOYPAD:
            begin
                // any key line falling raises the joypad interrupt
                if ((key_levels & ~wdata) != 8'h00)
                    page_mirror[R_IF][JOYPAD_LINE] = 1'b1;
                key_levels = wdata;
                page_mirror[R_P1] = p1_from_keys(page_mirror[R_P1], wdata);
            end
            OP_ENABLE:  irq_master_on = 1'b1;
            OP_DISABLE: irq_master_on = 1'b0;
            default:    ;
        endcase
        return res;
    endfunction

    // Idle span for either side: mostly none or short, now and then long.
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Drives one input transfer and records its expected result on acceptance.
    task automatic send_io_item(input stim_row_t row);
        io_result_t predicted;
        int gap;
        gap = idle_span();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= row.op;
        address    <= row.addr;
        data       <= row.data;
        irq_number <= row.line;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = step_io_page(row.op, row.addr, row.data, row.line);
        pending_results.push_back(row.typed ? row.want : predicted);
    endtask

    task automatic check_io_result();
        io_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result transfer with nothing expected");
            failures++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (read_data !== want.read_data)
            begin
                $error("read_data: expected %0h actual %0h", want.read_data, read_data);
                failures++;
            end
            if (undefined_access !== want.undefined_access)
            begin
                $error("undefined_access: expected %0h actual %0h",
                       want.undefined_access, undefined_access);
                failures++;
            end
            if (ack_valid !== want.ack_valid)
            begin
                $error("ack_valid: expected %0h actual %0h", want.ack_valid, ack_valid);
                failures++;
            end
            if (vector_address !== want.vector_address)
            begin
                $error("vector_address: expected %0h actual %0h",
                       want.vector_address, vector_address);
                failures++;
            end
            if (video_restart !== want.video_restart)
            begin
                $error("video_restart: expected %0h actual %0h", want.video_restart, video_restart);
                failures++;
            end
            if (dma_start !== want.dma_start)
            begin
                $error("dma_start: expected %0h actual %0h", want.dma_start, dma_start);
                failures++;
            end
            if (dma_page !== want.dma_page)
            begin
                $error("dma_page: expected %0h actual %0h", want.dma_page, dma_page);
                failures++;
            end
        end
    endtask

    // Result side: check every accepted transfer, then pick the next stretch
    // of ready or stall. One out_ready update per edge at most.
    initial
    begin
        int hold_left;
        int stall;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
                check_io_result();
            if (hold_left <= 0)
            begin
                stall = idle_span();
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    hold_left = stall;
                end
                else
                begin
                    out_ready <= 1'b1;
                    hold_left = $urandom_range(1, 8);
                end
            end
            hold_left = hold_left - 1;
        end
    end

    // Input side: reset, directed table, random traffic, drain, verdict.
    initial
    begin
        stim_row_t row;
        int pick;
        failures    = 0;
        cycle_count = 0;
        no_idle     = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        operation  <= OP_READ;
        address    <= 16'h0000;
        data       <= 8'h00;
        irq_number <= 3'd0;

        // Power-on shadow state
        for (int i = 0; i < 256; i++)
            page_mirror[i] = 8'h00;
        page_mirror[R_P1]   = 8'h0F;
        page_mirror[R_LCDC] = 8'h91;
        page_mirror[R_BGP]  = 8'hFC;
        page_mirror[R_OBP0] = 8'hFF;
        page_mirror[R_OBP1] = 8'hFF;
        irq_master_on = 1'b1;
        key_levels    = 8'hFF;

        // op, address, data, line, typed, known answer
        directed_rows = '{
            // reset values; high address byte ignored
            '{OP_READ,    16'hFF40, 8'h00, 3'd0, 1'b1, '{read_data: 8'h91, default: '0}},
            '{OP_READ,    16'h0000, 8'h00, 3'd0, 1'b1, '{read_data: 8'h0F, default: '0}},
            // hole in the map, and DMA read
            '{OP_READ,    16'h0003, 8'h00, 3'd0, 1'b1, '{undefined_access: 1'b1, default: '0}},
            '{OP_READ,    16'h0046, 8'h00, 3'd0, 1'b1, '{undefined_access: 1'b1, default: '0}},
            '{OP_WRITE,   16'hFF46, 8'hFF, 3'd0, 1'b1,
              '{dma_start: 1'b1, dma_page: 8'hFF, default: '0}},
            // nothing pending
            '{OP_ACK,     16'h0000, 8'h00, 3'd0, 1'b1, ALL_ZERO},
            '{OP_WRITE,   16'hFFFF, 8'hFF, 3'd0, 1'b1, '{read_data: 8'hFF, default: '0}},
            // line past the last interrupt is dropped
            '{OP_RAISE,   16'h0000, 8'h00, 3'd7, 1'b1, ALL_ZERO},
            '{OP_RAISE,   16'h0000, 8'h00, 3'd0, 1'b0, ALL_ZERO},
            '{OP_RAISE,   16'h0000, 8'h00, 3'd4, 1'b0, ALL_ZERO},
            '{OP_READ,    16'hFF0F, 8'h00, 3'd0, 1'b0, ALL_ZERO},
            // master enable off: IF reads zero, acknowledge finds nothing
            '{OP_DISABLE, 16'h0000, 8'h00, 3'd0, 1'b0, ALL_ZERO},
            '{OP_READ,    16'h000F, 8'h00, 3'd0, 1'b1, ALL_ZERO},
            '{OP_ACK,     16'h0000, 8'h00, 3'd0, 1'b1, ALL_ZERO},
            '{OP_ENABLE,  16'h0000, 8'h00, 3'd0, 1'b0, ALL_ZERO},
            '{OP_ACK,     16'h0000, 8'h00, 3'd0, 1'b0, ALL_ZERO},
            '{OP_ACK,     16'h0000, 8'h00, 3'd0, 1'b0, ALL_ZERO},
            // all keys fall: joypad interrupt comes back
            '{OP_JOYPAD,  16'h0000, 8'h00, 3'd0, 1'b0, ALL_ZERO},
            '{OP_WRITE,   16'h0000, 8'h20, 3'd0, 1'b0, ALL_ZERO},
            '{OP_WRITE,   16'h0041, 8'hFF, 3'd0, 1'b0, ALL_ZERO},
            '{OP_WRITE,   16'h0040, 8'h00, 3'd0, 1'b0, ALL_ZERO},
            '{OP_WRITE,   16'h0044, 8'hAA, 3'd0, 1'b1, '{video_restart: 1'b1, default: '0}},
            '{OP_WRITE,   16'h0004, 8'hFF, 3'd0, 1'b0, ALL_ZERO},
            '{OP_UNUSED,  16'hFFFF, 8'hFF, 3'd7, 1'b1, ALL_ZERO},
            '{OP_ACK,     16'h0000, 8'h00, 3'd0, 1'b0, ALL_ZERO}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_io_item(directed_rows[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // every 250 transfers, a 50-transfer burst with no idling
            no_idle = (n % 250) >= 200;
            row = '0;

            pick = $urandom_range(0, 99);
            if (pick < 24)      row.op = OP_READ;
            else if (pick < 48) row.op = OP_WRITE;
            else if (pick < 63) row.op = OP_RAISE;
            else if (pick < 78) row.op = OP_ACK;
            else if (pick < 87) row.op = OP_JOYPAD;
            else if (pick < 94) row.op = OP_ENABLE;
            else if (pick < 98) row.op = OP_DISABLE;
            else                row.op = OP_UNUSED;

            // bias toward registers with side effects, keep some full noise
            row.addr = 16'($urandom_range(0, 16'hFFFF));
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                case ($urandom_range(0, 10))
                    0:       row.addr[7:0] = R_P1;
                    1:       row.addr[7:0] = R_DIV;
                    2:       row.addr[7:0] = R_IF;
                    3:       row.addr[7:0] = R_LCDC;
                    4:       row.addr[7:0] = R_STAT;
                    5:       row.addr[7:0] = R_LY;
                    6:       row.addr[7:0] = R_DMA;
                    7:       row.addr[7:0] = R_BGP;
                    8:       row.addr[7:0] = R_OBP0;
                    9:       row.addr[7:0] = R_OBP1;
                    default: row.addr[7:0] = R_IE;
                endcase
            end
            else if (pick < 8)
                row.addr[7:0] = 8'($urandom_range(0, 8'h4B));

            // joypad: often a single key pressed, otherwise any pattern
            if (row.op == OP_JOYPAD && $urandom_range(0, 1) == 0)
                row.data = 8'hFF ^ (8'h01 << $urandom_range(0, 7));
            else
                row.data = 8'($urandom_range(0, 255));

            if ($urandom_range(0, 3) == 0)
                row.line = 3'($urandom_range(0, 7));
            else
                row.line = 3'($urandom_range(0, IRQ_LINES - 1));

            send_io_item(row);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("tb_handheld_io_interrupt_registers: PASS");
        else
            $display("tb_handheld_io_interrupt_registers: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/hhio_pkg.sv
rtl/hhio_ram.sv
rtl/hhio_page.sv
rtl/handheld_io_interrupt_registers.sv
verif/tb_handheld_io_interrupt_registers.sv
